>>> design/ohlc_pkg.sv
// Shared types and constants for the OHLC bar aggregator.
// No dependencies; compiled before the interfaces and modules.
package ohlc_pkg;

  localparam int STAMP_W     = 48;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WIDE_ROW       = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HAS_VOLUME     = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HAS_ADJUSTED   = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STAMP_AT_FIRST = 8'd3;

  typedef struct packed {
    logic wide_row;
    logic has_volume;
    logic has_adjusted;
    logic stamp_at_first;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    wide_row:       1'b1,
    has_volume:     1'b1,
    has_adjusted:   1'b0,
    stamp_at_first: 1'b0
  };

endpackage

>>> design/ohlc_row_if.sv
// Input row channel: valid/ready handshake with the row payload.
// Depends on ohlc_pkg for the stamp width.
interface ohlc_row_if
  import ohlc_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] open_value;
  logic signed [VALUE_WIDTH-1:0] high_value;
  logic signed [VALUE_WIDTH-1:0] low_value;
  logic signed [VALUE_WIDTH-1:0] close_value;
  logic signed [VALUE_WIDTH-1:0] volume_value;
  logic signed [VALUE_WIDTH-1:0] adjusted_value;
  logic        [STAMP_W-1:0]     stamp;
  logic                          period_end;

  modport source (
    output valid, open_value, high_value, low_value, close_value,
           volume_value, adjusted_value, stamp, period_end,
    input  ready
  );
  modport sink (
    input  valid, open_value, high_value, low_value, close_value,
           volume_value, adjusted_value, stamp, period_end,
    output ready
  );
endinterface

>>> design/ohlc_bar_if.sv
// Result bar channel: valid/ready handshake with the bar payload.
// Depends on ohlc_pkg for the stamp width.
interface ohlc_bar_if
  import ohlc_pkg::*;
#(
  parameter int VALUE_WIDTH  = 32,
  parameter int VOLUME_WIDTH = 48
);
  logic                           valid;
  logic                           ready;
  logic signed [VALUE_WIDTH-1:0]  bar_open;
  logic signed [VALUE_WIDTH-1:0]  bar_high;
  logic signed [VALUE_WIDTH-1:0]  bar_low;
  logic signed [VALUE_WIDTH-1:0]  bar_close;
  logic signed [VOLUME_WIDTH-1:0] bar_volume;
  logic signed [VALUE_WIDTH-1:0]  bar_adjusted;
  logic        [STAMP_W-1:0]      bar_stamp;

  modport source (
    output valid, bar_open, bar_high, bar_low, bar_close, bar_volume,
           bar_adjusted, bar_stamp,
    input  ready
  );
  modport sink (
    input  valid, bar_open, bar_high, bar_low, bar_close, bar_volume,
           bar_adjusted, bar_stamp,
    output ready
  );
endinterface

>>> design/ohlc_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on ohlc_pkg for the index and data widths.
interface ohlc_cfg_if
  import ohlc_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/ohlc_bar_aggregator.sv
// OHLC bar aggregator, top level.
// Uses ohlc_pkg, the ohlc_row_if / ohlc_bar_if / ohlc_cfg_if interfaces
// and ohlc_vol_acc.
//
// Rows arrive on in_row, one transaction per row. Each accepted row folds
// into the open period: the first row latches open and stamp, every row
// updates the running high, low and (if has_volume) saturated volume sum.
// A row with period_end set closes the period and loads one bar into the
// output register on out_bar; rows without it produce no transaction.
// Latency: the bar is valid the cycle after its closing row is accepted.
// Throughput: one row per cycle; the whole fold is one pass of compare
// and add logic between the period registers and the output register.
// in_row.ready drops only while a bar sits in the output register and
// out_bar.ready is low; then rows stall until the bar is taken.
// cfg writes (index 0..3: wide_row, has_volume, has_adjusted,
// stamp_at_first, bit 0 of data) are always accepted; other indexes are
// dropped. Write them only while no period is open and no bar is pending.
// Reset (rst_n low, synchronous) closes any open period, empties the
// output register and restores the register defaults.
module ohlc_bar_aggregator
  import ohlc_pkg::*;
#(
  parameter int VALUE_WIDTH  = 32,
  parameter int VOLUME_WIDTH = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  ohlc_row_if.sink    in_row,
  ohlc_bar_if.source  out_bar,
  ohlc_cfg_if.sink    cfg
);

  cfg_t cfg_r;

  logic                           in_period_r;
  logic signed [VALUE_WIDTH-1:0]  held_open_r;
  logic signed [VALUE_WIDTH-1:0]  run_high_r;
  logic signed [VALUE_WIDTH-1:0]  run_low_r;
  logic signed [VOLUME_WIDTH-1:0] vol_sum_r;
  logic        [STAMP_W-1:0]      first_stamp_r;

  logic                           out_valid_r;
  logic signed [VALUE_WIDTH-1:0]  bar_open_r;
  logic signed [VALUE_WIDTH-1:0]  bar_high_r;
  logic signed [VALUE_WIDTH-1:0]  bar_low_r;
  logic signed [VALUE_WIDTH-1:0]  bar_close_r;
  logic signed [VOLUME_WIDTH-1:0] bar_volume_r;
  logic signed [VALUE_WIDTH-1:0]  bar_adjusted_r;
  logic        [STAMP_W-1:0]      bar_stamp_r;

  logic                           row_accept;
  logic signed [VALUE_WIDTH-1:0]  row_high;
  logic signed [VALUE_WIDTH-1:0]  row_low;
  logic signed [VALUE_WIDTH-1:0]  row_close;
  logic signed [VALUE_WIDTH-1:0]  base_open;
  logic signed [VALUE_WIDTH-1:0]  base_high;
  logic signed [VALUE_WIDTH-1:0]  base_low;
  logic signed [VOLUME_WIDTH-1:0] base_sum;
  logic        [STAMP_W-1:0]      base_stamp;
  logic signed [VALUE_WIDTH-1:0]  high_nxt;
  logic signed [VALUE_WIDTH-1:0]  low_nxt;
  logic signed [VOLUME_WIDTH-1:0] sum_nxt;

  assign cfg.ready    = 1'b1;
  assign in_row.ready = !out_valid_r || out_bar.ready;
  assign row_accept   = in_row.valid && in_row.ready;

  // narrow rows take every price from column zero
  assign row_high  = cfg_r.wide_row ? in_row.high_value  : in_row.open_value;
  assign row_low   = cfg_r.wide_row ? in_row.low_value   : in_row.open_value;
  assign row_close = cfg_r.wide_row ? in_row.close_value : in_row.open_value;

  // the first row of a period seeds the running state
  assign base_open  = in_period_r ? held_open_r   : in_row.open_value;
  assign base_high  = in_period_r ? run_high_r    : row_high;
  assign base_low   = in_period_r ? run_low_r     : row_low;
  assign base_sum   = in_period_r ? vol_sum_r     : '0;
  assign base_stamp = in_period_r ? first_stamp_r : in_row.stamp;

  assign high_nxt = (base_high < row_high) ? row_high : base_high;
  assign low_nxt  = (row_low < base_low)   ? row_low  : base_low;

  ohlc_vol_acc #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .VOLUME_WIDTH (VOLUME_WIDTH)
  ) u_vol_acc (
    .en      (cfg_r.has_volume),
    .sum_in  (base_sum),
    .add_in  (in_row.volume_value),
    .sum_out (sum_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_WIDE_ROW:       cfg_r.wide_row       <= cfg.data[0];
        REG_HAS_VOLUME:     cfg_r.has_volume     <= cfg.data[0];
        REG_HAS_ADJUSTED:   cfg_r.has_adjusted   <= cfg.data[0];
        REG_STAMP_AT_FIRST: cfg_r.stamp_at_first <= cfg.data[0];
        default:            cfg_r                <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_period_r <= 1'b0;
    end else if (row_accept) begin
      in_period_r <= !in_row.period_end;
    end
  end

  always_ff @(posedge clk) begin
    if (row_accept) begin
      held_open_r   <= base_open;
      run_high_r    <= high_nxt;
      run_low_r     <= low_nxt;
      vol_sum_r     <= sum_nxt;
      first_stamp_r <= base_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (row_accept && in_row.period_end) begin
      out_valid_r <= 1'b1;
    end else if (out_bar.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_accept && in_row.period_end) begin
      bar_open_r     <= base_open;
      bar_high_r     <= high_nxt;
      bar_low_r      <= low_nxt;
      bar_close_r    <= row_close;
      bar_volume_r   <= cfg_r.has_volume ? sum_nxt : '0;
      bar_adjusted_r <= cfg_r.has_adjusted ? in_row.adjusted_value : '0;
      bar_stamp_r    <= cfg_r.stamp_at_first ? base_stamp : in_row.stamp;
    end
  end

  assign out_bar.valid        = out_valid_r;
  assign out_bar.bar_open     = bar_open_r;
  assign out_bar.bar_high     = bar_high_r;
  assign out_bar.bar_low      = bar_low_r;
  assign out_bar.bar_close    = bar_close_r;
  assign out_bar.bar_volume   = bar_volume_r;
  assign out_bar.bar_adjusted = bar_adjusted_r;
  assign out_bar.bar_stamp    = bar_stamp_r;

endmodule

>>> design/ohlc_vol_acc.sv
// Saturating volume accumulator: adds one row volume to the running sum
// and clamps to the signed range of the sum. Depends on no package.
module ohlc_vol_acc #(
  parameter int VALUE_WIDTH  = 32,
  parameter int VOLUME_WIDTH = 48
) (
  input  logic                           en,
  input  logic signed [VOLUME_WIDTH-1:0] sum_in,
  input  logic signed [VALUE_WIDTH-1:0]  add_in,
  output logic signed [VOLUME_WIDTH-1:0] sum_out
);

  localparam int EXT_W = ((VOLUME_WIDTH > VALUE_WIDTH) ? VOLUME_WIDTH : VALUE_WIDTH) + 1;
  localparam logic signed [EXT_W-1:0] SUM_MAX = (EXT_W'(1) << (VOLUME_WIDTH - 1)) - EXT_W'(1);
  localparam logic signed [EXT_W-1:0] SUM_MIN = ~SUM_MAX;

  logic signed [EXT_W-1:0] sum_ext;
  logic signed [EXT_W-1:0] add_ext;
  logic signed [EXT_W-1:0] total;

  assign sum_ext = {{(EXT_W - VOLUME_WIDTH){sum_in[VOLUME_WIDTH-1]}}, sum_in};
  assign add_ext = {{(EXT_W - VALUE_WIDTH){add_in[VALUE_WIDTH-1]}}, add_in};
  // exact in EXT_W bits: both operands fit in one bit less
  assign total   = sum_ext + add_ext;

  always_comb begin
    if (!en) begin
      sum_out = sum_in;
    end else if (total > SUM_MAX) begin
      sum_out = SUM_MAX[VOLUME_WIDTH-1:0];
    end else if (total < SUM_MIN) begin
      sum_out = SUM_MIN[VOLUME_WIDTH-1:0];
    end else begin
      sum_out = total[VOLUME_WIDTH-1:0];
    end
  end

endmodule

>>> sim/ohlc_bar_checker.sv
// Scoreboard for the OHLC bar aggregator: watches the row, bar and config channels,
// folds accepted rows into expected bars and compares every bar taken from the block.
// Depends on ohlc_pkg and the ohlc_row_if / ohlc_bar_if / ohlc_cfg_if interfaces.
module ohlc_bar_checker
  import ohlc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ohlc_row_if  row_ch,
  ohlc_bar_if  bar_ch,
  ohlc_cfg_if  cfg_ch,
  output int   mismatches,
  output int   bars_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [48:0] VOLUME_MAX = (49'sd1 <<< 47) - 49'sd1;
  localparam logic signed [48:0] VOLUME_MIN = -(49'sd1 <<< 47);

  typedef struct packed {
    logic signed [31:0]  open_px;
    logic signed [31:0]  high_px;
    logic signed [31:0]  low_px;
    logic signed [31:0]  close_px;
    logic signed [47:0]  volume;
    logic signed [31:0]  adjusted;
    logic [STAMP_W-1:0]  stamp;
  } bar_t;

  bar_t               expected_bars[$];
  cfg_t               regs;
  logic               period_open;
  logic signed [31:0] open_hold;
  logic signed [31:0] high_run;
  logic signed [31:0] low_run;
  logic signed [47:0] volume_run;
  logic [STAMP_W-1:0] stamp_hold;

  function automatic logic signed [47:0] add_clamped(logic signed [47:0] acc,
                                                     logic signed [31:0] vol);
    logic signed [48:0] total;
    total = acc + vol;
    if (total > VOLUME_MAX) return VOLUME_MAX[47:0];
    if (total < VOLUME_MIN) return VOLUME_MIN[47:0];
    return total[47:0];
  endfunction

  // Fold the row on the channel into the open period; queue a bar on period end.
  task automatic fold_row();
    logic signed [31:0] px_high;
    logic signed [31:0] px_low;
    logic signed [31:0] px_close;
    bar_t               bar;
    px_high  = regs.wide_row ? row_ch.high_value  : row_ch.open_value;
    px_low   = regs.wide_row ? row_ch.low_value   : row_ch.open_value;
    px_close = regs.wide_row ? row_ch.close_value : row_ch.open_value;
    if (!period_open) begin
      open_hold  = row_ch.open_value;
      high_run   = px_high;
      low_run    = px_low;
      volume_run = '0;
      stamp_hold = row_ch.stamp;
    end
    if (px_high > high_run) high_run = px_high;
    if (px_low < low_run) low_run = px_low;
    if (regs.has_volume) volume_run = add_clamped(volume_run, row_ch.volume_value);
    if (row_ch.period_end) begin
      bar.open_px  = open_hold;
      bar.high_px  = high_run;
      bar.low_px   = low_run;
      bar.close_px = px_close;
      bar.volume   = regs.has_volume ? volume_run : '0;
      bar.adjusted = regs.has_adjusted ? row_ch.adjusted_value : '0;
      bar.stamp    = regs.stamp_at_first ? stamp_hold : row_ch.stamp;
      expected_bars.push_back(bar);
    end
    period_open = !row_ch.period_end;
  endtask

  task automatic check_field(string label, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    bar_t want;
    if (!rst_n) begin
      regs        = CFG_RESET;
      period_open = 1'b0;
      open_hold   = '0;
      high_run    = '0;
      low_run     = '0;
      volume_run  = '0;
      stamp_hold  = '0;
      mismatches  = 0;
      expected_bars.delete();
    end else begin
      // Compare first: a bar closed at this edge cannot leave before the next one.
      if (bar_ch.valid && bar_ch.ready) begin
        if (expected_bars.size() == 0) begin
          $display("%0t: bar mismatch, expected none, actual open %0h stamp %0h",
                   $time, bar_ch.bar_open, bar_ch.bar_stamp);
          mismatches++;
        end else begin
          want = expected_bars.pop_front();
          check_field("bar_open", want.open_px, bar_ch.bar_open);
          check_field("bar_high", want.high_px, bar_ch.bar_high);
          check_field("bar_low", want.low_px, bar_ch.bar_low);
          check_field("bar_close", want.close_px, bar_ch.bar_close);
          check_field("bar_volume", want.volume, bar_ch.bar_volume);
          check_field("bar_adjusted", want.adjusted, bar_ch.bar_adjusted);
          check_field("bar_stamp", want.stamp, bar_ch.bar_stamp);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_WIDE_ROW:       regs.wide_row       = cfg_ch.data[0];
          REG_HAS_VOLUME:     regs.has_volume     = cfg_ch.data[0];
          REG_HAS_ADJUSTED:   regs.has_adjusted   = cfg_ch.data[0];
          REG_STAMP_AT_FIRST: regs.stamp_at_first = cfg_ch.data[0];
          default: ;
        endcase
      end
      if (row_ch.valid && row_ch.ready) fold_row();
    end
    bars_pending <= expected_bars.size();
  end

endmodule

>>> sim/testbench.sv
// Top of the OHLC bar aggregator bench: clock, reset, row and config stimulus,
// random back-pressure on the bar channel, and the final verdict.
// Depends on ohlc_pkg, the channel interfaces, ohlc_bar_aggregator and ohlc_bar_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ohlc_pkg::*;

  localparam int                 NUM_REGS    = 4;
  localparam int                 PHASE_ROWS  = 150;
  localparam int                 NUM_PHASES  = 8;
  localparam logic signed [31:0] PRICE_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PRICE_MIN   = 32'sh8000_0000;
  localparam logic [STAMP_W-1:0] STAMP_MAX   = '1;

  typedef struct {
    logic signed [31:0] open_value;
    logic signed [31:0] high_value;
    logic signed [31:0] low_value;
    logic signed [31:0] close_value;
    logic signed [31:0] volume_value;
    logic signed [31:0] adjusted_value;
    logic [STAMP_W-1:0] stamp;
    logic               period_end;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  bit                 no_gaps;
  int                 mismatches;
  int                 bars_pending;
  logic [STAMP_W-1:0] stamp_clock;

  ohlc_row_if row_ch ();
  ohlc_bar_if bar_ch ();
  ohlc_cfg_if cfg_ch ();

  ohlc_bar_aggregator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_row  (row_ch),
    .out_bar (bar_ch),
    .cfg     (cfg_ch)
  );

  ohlc_bar_checker scoreboard (
    .clk          (clk),
    .rst_n        (rst_n),
    .row_ch       (row_ch),
    .bar_ch       (bar_ch),
    .cfg_ch       (cfg_ch),
    .mismatches   (mismatches),
    .bars_pending (bars_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

  function automatic row_t row_of(logic signed [31:0] op, logic signed [31:0] hi,
                                  logic signed [31:0] lo, logic signed [31:0] cl,
                                  logic signed [31:0] vol, logic signed [31:0] adj,
                                  logic [STAMP_W-1:0] st, logic last);
    row_t row;
    row.open_value     = op;
    row.high_value     = hi;
    row.low_value      = lo;
    row.close_value    = cl;
    row.volume_value   = vol;
    row.adjusted_value = adj;
    row.stamp          = st;
    row.period_end     = last;
    return row;
  endfunction

  function automatic logic signed [31:0] rand_price();
    case ($urandom_range(0, 9))
      0:       return PRICE_MAX;
      1:       return PRICE_MIN;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4, 5, 6: return $signed(32'($urandom_range(0, 2000))) - 32'sd1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [STAMP_W-1:0] rand_stamp();
    stamp_clock += STAMP_W'($urandom_range(1, 100));
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return STAMP_MAX;
      2, 3:    return STAMP_W'({$urandom, $urandom});
      default: return stamp_clock;
    endcase
  endfunction

  function automatic row_t rand_row(logic last);
    return row_of(rand_price(), rand_price(), rand_price(), rand_price(), rand_price(),
                  rand_price(), rand_stamp(), last);
  endfunction

  // Hold the row until the block takes it; valid stays up for back-to-back rows.
  task automatic send_row(row_t row);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      row_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    row_ch.valid          <= 1'b1;
    row_ch.open_value     <= row.open_value;
    row_ch.high_value     <= row.high_value;
    row_ch.low_value      <= row.low_value;
    row_ch.close_value    <= row.close_value;
    row_ch.volume_value   <= row.volume_value;
    row_ch.adjusted_value <= row.adjusted_value;
    row_ch.stamp          <= row.stamp;
    row_ch.period_end     <= row.period_end;
    @(posedge clk);
    while (!row_ch.ready) @(posedge clk);
  endtask

  task automatic send_period(int rows);
    for (int i = 0; i < rows; i++) send_row(rand_row(i == rows - 1));
  endtask

  // Drop valid and wait until every bar is out, plus the output register latency.
  task automatic settle();
    row_ch.valid <= 1'b0;
    @(posedge clk);
    while (bars_pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] reg_index, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= reg_index;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Write all registers with junk in the upper data bits, sometimes hit a dead index.
  task automatic apply_settings(cfg_t setting);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    write_reg(REG_WIDE_ROW, {junk[CFG_DATA_W-1:1], setting.wide_row});
    junk = $urandom;
    write_reg(REG_HAS_VOLUME, {junk[CFG_DATA_W-1:1], setting.has_volume});
    junk = $urandom;
    write_reg(REG_HAS_ADJUSTED, {junk[CFG_DATA_W-1:1], setting.has_adjusted});
    junk = $urandom;
    write_reg(REG_STAMP_AT_FIRST, {junk[CFG_DATA_W-1:1], setting.stamp_at_first});
    if ($urandom_range(0, 1) == 0)
      write_reg(CFG_INDEX_W'($urandom_range(NUM_REGS, 255)), $urandom);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : bar_taker
    int stall;
    bar_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        bar_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      bar_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(bar_ch.valid && bar_ch.ready)) @(posedge clk);
    end
  end

  initial begin : stimulus
    cfg_t setting;
    int   phase_rows;
    int   len;
    row_ch.valid          <= 1'b0;
    row_ch.open_value     <= '0;
    row_ch.high_value     <= '0;
    row_ch.low_value      <= '0;
    row_ch.close_value    <= '0;
    row_ch.volume_value   <= '0;
    row_ch.adjusted_value <= '0;
    row_ch.stamp          <= '0;
    row_ch.period_end     <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= '0;
    cfg_ch.data           <= '0;
    stamp_clock = '0;
    no_gaps     = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: single-row bars at the field extremes, then a short period.
    send_row(row_of(PRICE_MAX, PRICE_MAX, PRICE_MIN, PRICE_MIN, PRICE_MAX, PRICE_MIN,
                    STAMP_MAX, 1'b1));
    send_row(row_of(PRICE_MIN, PRICE_MIN, PRICE_MAX, PRICE_MAX, PRICE_MIN, PRICE_MAX,
                    '0, 1'b1));
    send_row(row_of(100, 150, 90, 120, 10, 7, 1000, 1'b0));
    send_row(row_of(110, 200, 95, 105, -30, 8, 1001, 1'b0));
    send_row(row_of(105, 130, 50, 101, 5, 9, 1002, 1'b1));
    settle();

    // Narrow rows, no volume, adjusted on, first stamp.
    apply_settings('{wide_row: 1'b0, has_volume: 1'b0, has_adjusted: 1'b1,
                     stamp_at_first: 1'b1});
    send_row(row_of(100, 150, 90, 120, 10, 7, 2000, 1'b0));
    send_row(row_of(-40, 200, 95, 105, -30, 8, 2001, 1'b0));
    send_row(row_of(300, 130, 50, 101, 5, 9, 2002, 1'b1));
    send_row(row_of(PRICE_MIN, PRICE_MAX, PRICE_MAX, PRICE_MAX, PRICE_MAX, PRICE_MAX,
                    STAMP_MAX, 1'b1));
    settle();
    apply_settings('{wide_row: 1'b1, has_volume: 1'b0, has_adjusted: 1'b1,
                     stamp_at_first: 1'b0});
    send_row(row_of(7, -3, 12, 8, PRICE_MAX, -5, 3000, 1'b0));
    send_row(row_of(9, -9, -12, 1, PRICE_MAX, -6, 3001, 1'b1));
    settle();

    // Random periods under a range of settings, both extremes first.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 0) setting = '0;
      else if (phase == 1) setting = '1;
      else setting = cfg_t'(4'($urandom_range(0, 15)));
      apply_settings(setting);
      phase_rows = 0;
      while (phase_rows < PHASE_ROWS) begin
        if ($urandom_range(0, 7) == 0) no_gaps = !no_gaps;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 16) : $urandom_range(1, 3);
        send_period(len);
        phase_rows += len;
      end
      settle();
    end

    if (mismatches == 0 && bars_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
